FILE: rtl/vsws_pkg.sv
// Shared constants, register codes and controller/datapath interface types.
`default_nettype none

package vsws_pkg;

    // Window depth default and fixed field widths.
    localparam int WINDOW_DEF = 100;
    localparam int DATA_W     = 18;
    localparam int SAMPLE_W   = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;
    localparam int CNT7_W     = 7;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VALID_LOW  = 3'd0,
        CFG_VALID_HIGH = 3'd1,
        CFG_AVG_ENABLE = 3'd2,
        CFG_MIN_VALID  = 3'd3,
        CFG_LOOKBACK   = 3'd4
    } t_cfg_idx;

    // Configuration reset values.
    localparam logic signed [DATA_W-1:0] VALID_LOW_RST  = -18'sd40000;
    localparam logic signed [DATA_W-1:0] VALID_HIGH_RST = 18'sd125000;
    localparam logic                     AVG_ENABLE_RST = 1'b1;
    localparam logic [CNT7_W-1:0]        MIN_VALID_RST  = 7'd50;
    localparam logic [CNT7_W-1:0]        LOOKBACK_RST   = 7'd10;

    // Operation codes of an input beat.
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic clear;
        logic update;
        logic start_div;
        logic scan_init;
        logic scan_step;
        logic fetch_done;
        logic avg_load;
        logic finish;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_clear;
        logic div_needed;
        logic div_done;
        logic scan_end;
        logic scan_hit;
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

FILE: rtl/vsws_div.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
`default_nettype none

module vsws_div
    import vsws_pkg::*;
#(
    parameter int NUM_W = 25,
    parameter int DEN_W = 7
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_start,
    input  wire signed [NUM_W-1:0]  i_num,
    input  wire        [DEN_W-1:0]  i_den,
    output logic                    o_done,
    output logic signed [NUM_W-1:0] o_quot
);

    localparam int STEP_W = $clog2(NUM_W + 1);

    logic              r_busy;
    logic              r_done;
    logic              r_neg;
    logic [NUM_W-1:0]  r_quo;
    logic [DEN_W-1:0]  r_rem;
    logic [DEN_W-1:0]  r_den;
    logic [STEP_W-1:0] r_step;

    logic [DEN_W:0]    w_trial;
    logic              w_fits;
    logic [DEN_W:0]    w_diff;

    // One restoring step: shift in the next dividend bit and try the subtract.
    assign w_trial = {r_rem, r_quo[NUM_W-1]};
    assign w_fits  = (w_trial >= {1'b0, r_den});
    assign w_diff  = w_trial - {1'b0, r_den};

    // Control of the iteration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(NUM_W);
            end else if (r_busy) begin
                r_step <= r_step - 1'b1;
                if (r_step == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Magnitude division with the sign applied at the end.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_num[NUM_W-1];
            r_quo <= i_num[NUM_W-1] ? (-i_num) : i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= w_fits ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
            r_quo <= {r_quo[NUM_W-2:0], w_fits};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? (-r_quo) : r_quo;

endmodule

`default_nettype wire

FILE: rtl/vsws_dp.sv
// Datapath: configuration, window store, running sum, statistics and output register.
`default_nettype none

module vsws_dp
    import vsws_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  t_dp_cmd                     i_cmd,
    output t_dp_stat                    o_stat,
    input  wire                         i_cfg_valid,
    input  wire  [CFG_IDX_W-1:0]        i_cfg_index,
    input  wire  [CFG_DATA_W-1:0]       i_cfg_data,
    input  wire                         i_op,
    input  wire  signed [SAMPLE_W-1:0]  i_sample_in,
    input  wire                         i_out_ready,
    output logic                        o_out_valid,
    output logic signed [DATA_W-1:0]    o_current_value,
    output logic                        o_current_ok,
    output logic signed [DATA_W-1:0]    o_avg_value,
    output logic                        o_avg_ok,
    output logic signed [DATA_W-1:0]    o_max_value,
    output logic                        o_max_ok,
    output logic signed [DATA_W-1:0]    o_recent_value,
    output logic                        o_recent_ok
);

    localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int SUM_W = DATA_W + CNT_W;
    localparam int EXT_W = SAMPLE_W - DATA_W;

    // Configuration registers.
    logic signed [DATA_W-1:0] r_valid_low;
    logic signed [DATA_W-1:0] r_valid_high;
    logic                     r_avg_enable;
    logic [CNT7_W-1:0]        r_min_valid;
    logic [CNT7_W-1:0]        r_lookback;

    // Window store: valid bits in flops, values in a memory.
    logic [WINDOW-1:0]        r_valid;
    logic [DATA_W-1:0]        r_mem [WINDOW];
    logic [DATA_W-1:0]        r_rd_data;
    logic [IDX_W-1:0]         r_wr_idx;

    // Statistics state.
    logic signed [SUM_W-1:0]  r_sum;
    logic [CNT_W-1:0]         r_count;
    logic                     r_new_ok;
    logic signed [DATA_W-1:0] r_new_val;
    logic                     r_cur_ok;
    logic signed [DATA_W-1:0] r_cur_val;
    logic                     r_avg_ok;
    logic signed [DATA_W-1:0] r_avg_val;
    logic                     r_max_ok;
    logic signed [DATA_W-1:0] r_max_val;

    // Lookback scan state.
    logic [IDX_W-1:0]         r_scan_idx;
    logic [CNT_W-1:0]         r_scan_left;
    logic                     r_rec_ok;
    logic signed [DATA_W-1:0] r_rec_val;

    // Output register.
    logic                     r_out_valid;
    logic signed [DATA_W-1:0] r_o_cur_val;
    logic                     r_o_cur_ok;
    logic signed [DATA_W-1:0] r_o_avg_val;
    logic                     r_o_avg_ok;
    logic signed [DATA_W-1:0] r_o_max_val;
    logic                     r_o_max_ok;
    logic signed [DATA_W-1:0] r_o_rec_val;
    logic                     r_o_rec_ok;

    logic signed [SAMPLE_W-1:0] w_low_ext;
    logic signed [SAMPLE_W-1:0] w_high_ext;
    logic                       w_in_range;
    logic                       w_old_ok;
    logic signed [SUM_W-1:0]    w_old_term;
    logic signed [SUM_W-1:0]    w_new_term;
    logic [IDX_W-1:0]           w_wr_next;
    logic [IDX_W-1:0]           w_scan_prev;
    logic [CNT_W-1:0]           w_lb_sat;
    logic                       w_div_done;
    logic signed [SUM_W-1:0]    w_quot;

    // Range check of the incoming sample against sign-extended limits.
    assign w_low_ext  = {{EXT_W{r_valid_low[DATA_W-1]}}, r_valid_low};
    assign w_high_ext = {{EXT_W{r_valid_high[DATA_W-1]}}, r_valid_high};
    assign w_in_range = (i_sample_in >= w_low_ext) && (i_sample_in <= w_high_ext);

    // Contributions of the overwritten entry and the new entry to the sum.
    assign w_old_ok   = r_valid[r_wr_idx];
    assign w_old_term = w_old_ok ? {{CNT_W{r_rd_data[DATA_W-1]}}, r_rd_data} : '0;
    assign w_new_term = r_new_ok ? {{CNT_W{r_new_val[DATA_W-1]}}, r_new_val} : '0;

    // Ring index arithmetic.
    assign w_wr_next   = (r_wr_idx == IDX_W'(WINDOW - 1)) ? '0 : r_wr_idx + 1'b1;
    assign w_scan_prev = (r_scan_idx == '0) ? IDX_W'(WINDOW - 1) : r_scan_idx - 1'b1;
    assign w_lb_sat    = (int'(r_lookback) > WINDOW) ? CNT_W'(WINDOW) : CNT_W'(r_lookback);

    // Status toward the controller.
    assign o_stat.is_clear   = (i_op == OP_CLEAR);
    assign o_stat.div_needed = r_cur_ok && r_avg_enable && (r_count != '0)
                               && (int'(r_count) >= int'(r_min_valid));
    assign o_stat.div_done   = w_div_done;
    assign o_stat.scan_end   = r_cur_ok || (r_scan_left == '0);
    assign o_stat.scan_hit   = r_valid[w_scan_prev];
    assign o_stat.out_free   = !r_out_valid || i_out_ready;

    // Configuration writes; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_low  <= VALID_LOW_RST;
            r_valid_high <= VALID_HIGH_RST;
            r_avg_enable <= AVG_ENABLE_RST;
            r_min_valid  <= MIN_VALID_RST;
            r_lookback   <= LOOKBACK_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_VALID_LOW:  r_valid_low  <= i_cfg_data;
                CFG_VALID_HIGH: r_valid_high <= i_cfg_data;
                CFG_AVG_ENABLE: r_avg_enable <= i_cfg_data[0];
                CFG_MIN_VALID:  r_min_valid  <= i_cfg_data[CNT7_W-1:0];
                CFG_LOOKBACK:   r_lookback   <= i_cfg_data[CNT7_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Window memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_mem[r_wr_idx] <= r_new_val;
        end
        if (i_cmd.load) begin
            r_rd_data <= r_mem[r_wr_idx];
        end else if (i_cmd.scan_step) begin
            r_rd_data <= r_mem[w_scan_prev];
        end
    end

    // Latch the checked sample of an accepted beat.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_new_ok  <= w_in_range;
            r_new_val <= w_in_range ? i_sample_in[DATA_W-1:0] : '0;
        end
    end

    // Window bookkeeping and running statistics.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_valid   <= '0;
            r_wr_idx  <= '0;
            r_sum     <= '0;
            r_count   <= '0;
            r_cur_ok  <= 1'b0;
            r_cur_val <= '0;
            r_avg_ok  <= 1'b0;
            r_avg_val <= '0;
            r_max_ok  <= 1'b0;
            r_max_val <= '0;
        end else begin
            if (i_cmd.update) begin
                r_valid[r_wr_idx] <= r_new_ok;
                r_wr_idx  <= w_wr_next;
                r_sum     <= r_sum - w_old_term + w_new_term;
                r_count   <= r_count + CNT_W'(r_new_ok) - CNT_W'(w_old_ok);
                r_cur_ok  <= r_new_ok;
                r_cur_val <= r_new_val;
                if (r_new_ok && (!r_max_ok || (r_max_val < r_new_val))) begin
                    r_max_ok  <= 1'b1;
                    r_max_val <= r_new_val;
                end
            end
            if (i_cmd.avg_load) begin
                r_avg_ok  <= 1'b1;
                r_avg_val <= w_quot[DATA_W-1:0];
            end
        end
    end

    // Newest-first search of the lookback entries.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.load) begin
            r_rec_ok    <= 1'b0;
            r_scan_left <= '0;
        end else begin
            if (i_cmd.scan_init) begin
                r_scan_idx  <= r_wr_idx;
                r_scan_left <= w_lb_sat;
            end else if (i_cmd.scan_step) begin
                r_scan_idx  <= w_scan_prev;
                r_scan_left <= o_stat.scan_hit ? '0 : r_scan_left - 1'b1;
            end
            if (i_cmd.fetch_done) begin
                r_rec_ok  <= 1'b1;
                r_rec_val <= r_rd_data;
            end
        end
    end

    // Output register holds a finished result until it is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_o_cur_val <= r_cur_val;
            r_o_cur_ok  <= r_cur_ok;
            r_o_avg_val <= r_avg_val;
            r_o_avg_ok  <= r_avg_ok;
            r_o_max_val <= r_max_val;
            r_o_max_ok  <= r_max_ok;
            r_o_rec_ok  <= r_cur_ok || r_rec_ok;
            r_o_rec_val <= r_cur_ok ? r_cur_val : (r_rec_ok ? r_rec_val : '0);
        end
    end

    // Average divider.
    vsws_div #(
        .NUM_W (SUM_W),
        .DEN_W (CNT_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.start_div),
        .i_num   (r_sum),
        .i_den   (r_count),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    assign o_out_valid     = r_out_valid;
    assign o_current_value = r_o_cur_val;
    assign o_current_ok    = r_o_cur_ok;
    assign o_avg_value     = r_o_avg_val;
    assign o_avg_ok        = r_o_avg_ok;
    assign o_max_value     = r_o_max_val;
    assign o_max_ok        = r_o_max_ok;
    assign o_recent_value  = r_o_rec_val;
    assign o_recent_ok     = r_o_rec_ok;

endmodule

`default_nettype wire

FILE: rtl/vsws_ctrl.sv
// Controller state machine sequencing update, divide, lookback scan and result.
`default_nettype none

module vsws_ctrl
    import vsws_pkg::*;
(
    input  wire      i_clk,
    input  wire      i_rst_n,
    input  wire      i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_UPDATE = 7'b0000010,
        S_CHECK  = 7'b0000100,
        S_DIV    = 7'b0001000,
        S_SCAN   = 7'b0010000,
        S_FETCH  = 7'b0100000,
        S_FINISH = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_stat.is_clear) begin
                        o_cmd.clear = 1'b1;
                        n_state     = S_FINISH;
                    end else begin
                        n_state = S_UPDATE;
                    end
                end
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = S_CHECK;
            end
            S_CHECK: begin
                o_cmd.scan_init = 1'b1;
                if (i_stat.div_needed) begin
                    o_cmd.start_div = 1'b1;
                    n_state         = S_DIV;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    o_cmd.avg_load = 1'b1;
                    n_state        = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_stat.scan_end) begin
                    n_state = S_FINISH;
                end else begin
                    o_cmd.scan_step = 1'b1;
                    if (i_stat.scan_hit) begin
                        n_state = S_FETCH;
                    end
                end
            end
            S_FETCH: begin
                o_cmd.fetch_done = 1'b1;
                n_state          = S_FINISH;
            end
            S_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/validated_sample_window_stats.sv
// Top level of the validated sample window statistics block.
//
// Each input beat is either a new sample or a clear. A sample is range-checked
// against valid_low..valid_high, written into a ring of WINDOW entries, and
// updates the current value, the running maximum and, when enabled and enough
// entries are valid, the window average. Every beat yields one result beat with
// current, average, maximum and the most recent valid sample within lookback
// entries. A clear goes straight to the result; a sample passes through the
// update and check steps, then the average divide or the newest-first lookback
// scan (with a fetch on a hit), and then the result. The bit-serial divider runs
// for a valid sample when the average is recomputed; its numerator has
// SUM_W = 18 + clog2(WINDOW + 1) bits, 25 at the default. An invalid sample
// instead reads at most min(lookback, WINDOW) window entries in the scan; a hit
// ends the scan early. The two never occur for the same sample. The input opens
// in the cycle after the result is loaded. One item is worked on at a time;
// the next beat is taken while a finished result still waits in the output
// register, and that item then waits for the register to free up.
// Configuration writes are taken at any cycle and belong in idle periods.
`default_nettype none

module validated_sample_window_stats
    import vsws_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_in_valid,
    output logic                        o_in_ready,
    input  wire                         i_op,
    input  wire  signed [SAMPLE_W-1:0]  i_sample_in,
    output logic                        o_out_valid,
    input  wire                         i_out_ready,
    output logic signed [DATA_W-1:0]    o_current_value,
    output logic                        o_current_ok,
    output logic signed [DATA_W-1:0]    o_avg_value,
    output logic                        o_avg_ok,
    output logic signed [DATA_W-1:0]    o_max_value,
    output logic                        o_max_ok,
    output logic signed [DATA_W-1:0]    o_recent_value,
    output logic                        o_recent_ok,
    input  wire                         i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire  [CFG_IDX_W-1:0]        i_cfg_index,
    input  wire  [CFG_DATA_W-1:0]       i_cfg_data
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // Configuration registers accept a write every cycle.
    assign o_cfg_ready = 1'b1;

    // Sequencer.
    vsws_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // Window store, statistics and output register.
    vsws_dp #(
        .WINDOW (WINDOW)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_op            (i_op),
        .i_sample_in     (i_sample_in),
        .i_out_ready     (i_out_ready),
        .o_out_valid     (o_out_valid),
        .o_current_value (o_current_value),
        .o_current_ok    (o_current_ok),
        .o_avg_value     (o_avg_value),
        .o_avg_ok        (o_avg_ok),
        .o_max_value     (o_max_value),
        .o_max_ok        (o_max_ok),
        .o_recent_value  (o_recent_value),
        .o_recent_ok     (o_recent_ok)
    );

    // An accepted beat keeps the input closed for at least the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted again right after a beat");

    // An average exists only after some valid sample, so a maximum exists too.
    a_avg_needs_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_avg_ok) |-> o_max_ok)
        else $error("average reported without a maximum");

    // A valid current sample is always the recent sample.
    a_recent_is_current: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_current_ok) |-> (o_recent_ok && (o_recent_value == o_current_value)))
        else $error("recent value differs from valid current value");

    // Without a valid current sample the reported current value is zero.
    a_current_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_current_ok) |-> (o_current_value == '0))
        else $error("invalid current value is not zero");

endmodule

`default_nettype wire

FILE: sim/testbench.sv
// Self-checking testbench for the validated sample window statistics block.
module testbench;
    import vsws_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIN            = WINDOW_DEF;
    localparam int HOLD_CYCLES    = 600;
    localparam int WATCHDOG_LIMIT = 6000;
    localparam int DRAIN_CYCLES   = 300;
    localparam int INT_MAX_S      = 32'h7fffffff;
    localparam int INT_MIN_S      = 32'h80000000;

    // One input beat waiting to be offered to the block.
    typedef struct {
        logic                       op;
        logic signed [SAMPLE_W-1:0] sample;
    } t_sample_beat;

    // One result beat, field for field as the block reports it.
    typedef struct packed {
        logic signed [DATA_W-1:0] current_value;
        logic                     current_ok;
        logic signed [DATA_W-1:0] avg_value;
        logic                     avg_ok;
        logic signed [DATA_W-1:0] max_value;
        logic                     max_ok;
        logic signed [DATA_W-1:0] recent_value;
        logic                     recent_ok;
    } t_window_stats;

    // Clock, reset and block inputs, all known from time zero.
    logic                       i_clk       = 1'b0;
    logic                       rst_n       = 1'b0;
    logic                       in_valid    = 1'b0;
    logic                       in_op       = OP_SAMPLE;
    logic signed [SAMPLE_W-1:0] in_sample   = '0;
    logic                       out_ready   = 1'b0;
    logic                       cfg_valid   = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index   = CFG_VALID_LOW;
    logic [CFG_DATA_W-1:0]      cfg_data    = '0;

    wire                        o_in_ready;
    wire                        o_out_valid;
    wire                        o_cfg_ready;
    wire signed [DATA_W-1:0]    o_current_value;
    wire                        o_current_ok;
    wire signed [DATA_W-1:0]    o_avg_value;
    wire                        o_avg_ok;
    wire signed [DATA_W-1:0]    o_max_value;
    wire                        o_max_ok;
    wire signed [DATA_W-1:0]    o_recent_value;
    wire                        o_recent_ok;

    // Stimulus queue, expected results and progress counters.
    t_sample_beat  sample_beats_q[$];
    t_window_stats expected_stats_q[$];
    int            beats_queued    = 0;
    int            beats_accepted  = 0;
    int            results_checked = 0;
    int            error_count     = 0;
    int            send_idle_pct   = 0;
    int            recv_stall_pct  = 0;
    bit            hold_req        = 1'b0;
    int            hold_left       = 0;
    int            quiet_cycles    = 0;

    // Shadow of the configuration registers.
    int cfg_low;
    int cfg_high;
    bit cfg_avg_en;
    int cfg_min_valid;
    int cfg_lookback;

    // Shadow of the window and running statistics.
    bit win_ok [WIN];
    int win_val [WIN];
    int wr_idx;
    bit cur_ok;
    int cur_val;
    bit avg_ok;
    int avg_val;
    bit max_ok;
    int max_val;

    validated_sample_window_stats #(
        .WINDOW(WIN)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (o_in_ready),
        .i_op            (in_op),
        .i_sample_in     (in_sample),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (out_ready),
        .o_current_value (o_current_value),
        .o_current_ok    (o_current_ok),
        .o_avg_value     (o_avg_value),
        .o_avg_ok        (o_avg_ok),
        .o_max_value     (o_max_value),
        .o_max_ok        (o_max_ok),
        .o_recent_value  (o_recent_value),
        .o_recent_ok     (o_recent_ok),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Invalidate the whole window and all running statistics.
    function automatic void clear_window();
        for (int k = 0; k < WIN; k++) begin
            win_ok[k]  = 1'b0;
            win_val[k] = 0;
        end
        wr_idx  = 0;
        cur_ok  = 1'b0;
        cur_val = 0;
        avg_ok  = 1'b0;
        avg_val = 0;
        max_ok  = 1'b0;
        max_val = 0;
    endfunction

    // Apply one beat to the shadow state and return the result it must produce.
    function automatic t_window_stats window_stats_step(logic op, logic signed [SAMPLE_W-1:0] smp);
        t_window_stats r;
        int s;
        bit ok;
        int v;
        int sum;
        int cnt;
        int n;
        int idx;
        int j;
        bit r_ok;
        int r_val;
        if (op == OP_CLEAR) begin
            clear_window();
        end else begin
            s  = smp;
            ok = (s >= cfg_low) && (s <= cfg_high);
            v  = ok ? s : 0;
            win_ok[wr_idx]  = ok;
            win_val[wr_idx] = v;
            wr_idx  = (wr_idx + 1) % WIN;
            cur_ok  = ok;
            cur_val = v;
            if (ok) begin
                if (!max_ok || max_val < v) begin
                    max_val = v;
                    max_ok  = 1'b1;
                end
                // Average over valid entries, only once enough of them are present.
                if (cfg_avg_en) begin
                    sum = 0;
                    cnt = 0;
                    for (int k = 0; k < WIN; k++) begin
                        if (win_ok[k]) begin
                            sum += win_val[k];
                            cnt++;
                        end
                    end
                    if (cnt != 0 && cnt >= cfg_min_valid) begin
                        avg_val = sum / cnt;
                        avg_ok  = 1'b1;
                    end
                end
            end
        end
        // Most recent valid sample: current first, then newest window entries backwards.
        r_ok  = 1'b0;
        r_val = 0;
        if (cur_ok) begin
            r_ok  = 1'b1;
            r_val = cur_val;
        end else begin
            n   = (cfg_lookback > WIN) ? WIN : cfg_lookback;
            idx = wr_idx;
            for (j = 0; j < n && !r_ok; j++) begin
                idx = (idx == 0) ? WIN - 1 : idx - 1;
                if (win_ok[idx]) begin
                    r_ok  = 1'b1;
                    r_val = win_val[idx];
                end
            end
        end
        r.current_value = cur_ok ? cur_val[DATA_W-1:0] : '0;
        r.current_ok    = cur_ok;
        r.avg_value     = avg_ok ? avg_val[DATA_W-1:0] : '0;
        r.avg_ok        = avg_ok;
        r.max_value     = max_ok ? max_val[DATA_W-1:0] : '0;
        r.max_ok        = max_ok;
        r.recent_value  = r_ok ? r_val[DATA_W-1:0] : '0;
        r.recent_ok     = r_ok;
        return r;
    endfunction

    // Driver: offer queued beats, record the expected result of each accepted one.
    always @(posedge i_clk) begin : drive_beats
        t_sample_beat beat;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_in_ready) begin
                expected_stats_q.push_back(window_stats_step(in_op, in_sample));
                beats_accepted++;
            end
            if (!in_valid || o_in_ready) begin
                if (sample_beats_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    beat = sample_beats_q.pop_front();
                    in_valid  <= 1'b1;
                    in_op     <= beat.op;
                    in_sample <= beat.sample;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic report_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, exp_v, act_v);
            error_count++;
        end
    endtask

    // Monitor: compare each result beat with the oldest expectation and pace out_ready.
    always @(posedge i_clk) begin : check_results
        t_window_stats exp_r;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_out_valid && out_ready) begin
                if (expected_stats_q.size() == 0) begin
                    $display("%0t: result beat with nothing expected", $realtime);
                    error_count++;
                end else begin
                    exp_r = expected_stats_q.pop_front();
                    results_checked++;
                    report_field("current_value", exp_r.current_value, o_current_value);
                    report_field("current_ok", exp_r.current_ok, o_current_ok);
                    report_field("avg_value", exp_r.avg_value, o_avg_value);
                    report_field("avg_ok", exp_r.avg_ok, o_avg_ok);
                    report_field("max_value", exp_r.max_value, o_max_value);
                    report_field("max_ok", exp_r.max_ok, o_max_ok);
                    report_field("recent_value", exp_r.recent_value, o_recent_value);
                    report_field("recent_ok", exp_r.recent_ok, o_recent_ok);
                end
            end
            // A long hold-off takes precedence over the random stalls.
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
                out_ready <= 1'b0;
            end else begin
                out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // Watchdog: end the run when no channel moves a beat for too long.
    always @(posedge i_clk) begin
        if (!rst_n || (in_valid && o_in_ready) || (o_out_valid && out_ready)
                || (cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("validated_sample_window_stats regression: fail");
            $finish;
        end
    end

    // Write one configuration register and mirror it in the shadow copy.
    task automatic write_reg(input t_cfg_idx idx, input int value);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_VALID_LOW:  cfg_low       = $signed(value[DATA_W-1:0]);
            CFG_VALID_HIGH: cfg_high      = $signed(value[DATA_W-1:0]);
            CFG_AVG_ENABLE: cfg_avg_en    = value[0];
            CFG_MIN_VALID:  cfg_min_valid = value & 32'h7f;
            CFG_LOOKBACK:   cfg_lookback  = value & 32'h7f;
            default: ;
        endcase
    endtask

    task automatic set_config(input int lo, input int hi, input int avg_en, input int min_v,
                              input int look);
        write_reg(CFG_VALID_LOW, lo);
        write_reg(CFG_VALID_HIGH, hi);
        write_reg(CFG_AVG_ENABLE, avg_en);
        write_reg(CFG_MIN_VALID, min_v);
        write_reg(CFG_LOOKBACK, look);
    endtask

    task automatic queue_beat(input logic op, input int smp);
        t_sample_beat beat;
        beat.op     = op;
        beat.sample = smp;
        sample_beats_q.push_back(beat);
        beats_queued++;
    endtask

    // Block until every queued beat has been accepted and answered.
    task automatic wait_drained();
        do @(posedge i_clk);
        while (!(beats_accepted == beats_queued && results_checked == beats_accepted));
    endtask

    // Queue random beats: in-range samples, some clears, the rest range edges or wild values.
    task automatic queue_random(input int count, input int valid_pct, input int clear_pct);
        int r;
        int smp;
        for (int k = 0; k < count; k++) begin
            r = $urandom_range(0, 99);
            if (r < clear_pct) begin
                queue_beat(OP_CLEAR, $urandom);
            end else if (r < clear_pct + valid_pct) begin
                if (cfg_low <= cfg_high)
                    smp = cfg_low + $urandom_range(0, cfg_high - cfg_low);
                else
                    smp = $urandom_range(0, 262143) - 131072;
                queue_beat(OP_SAMPLE, smp);
            end else begin
                case ($urandom_range(0, 3))
                    0: begin
                        case ($urandom_range(0, 3))
                            0: smp = cfg_low - 1;
                            1: smp = cfg_low;
                            2: smp = cfg_high;
                            default: smp = cfg_high + 1;
                        endcase
                    end
                    1: smp = $urandom;
                    2: smp = $urandom_range(0, 262143) - 131072;
                    default: begin
                        case ($urandom_range(0, 3))
                            0: smp = INT_MIN_S;
                            1: smp = INT_MAX_S;
                            2: smp = 0;
                            default: smp = -1;
                        endcase
                    end
                endcase
                queue_beat(OP_SAMPLE, smp);
            end
        end
    endtask

    // Pacing mode: 0 none, 1 sender mostly idle, 2 receiver mostly stalled, 3 both lightly.
    task automatic set_pacing(input int mode);
        case (mode)
            1:       begin send_idle_pct = 88; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 88; end
            3:       begin send_idle_pct = 6;  recv_stall_pct = 6;  end
            default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        endcase
    endtask

    // A random phase in two halves, the sender pausing in between until all results are in.
    task automatic run_phase(input int mode, input int valid_pct, input int clear_pct,
                             input bit long_hold);
        set_pacing(mode);
        queue_random(120, valid_pct, clear_pct);
        if (long_hold)
            hold_req = 1'b1;
        wait_drained();
        set_pacing($urandom_range(0, 3));
        queue_random(120, valid_pct, clear_pct);
        wait_drained();
    endtask

    initial begin : run_test
        int lo;
        int hi;
        int tmp;
        cfg_low       = VALID_LOW_RST;
        cfg_high      = VALID_HIGH_RST;
        cfg_avg_en    = AVG_ENABLE_RST;
        cfg_min_valid = MIN_VALID_RST;
        cfg_lookback  = LOOKBACK_RST;
        clear_window();
        repeat (2) @(posedge i_clk);
        rst_n <= 1'b1;

        // Directed: range edges and extreme raw samples at reset settings.
        queue_beat(OP_CLEAR, 32'h5a5a5a5a);
        queue_beat(OP_SAMPLE, 0);
        queue_beat(OP_SAMPLE, -40000);
        queue_beat(OP_SAMPLE, -40001);
        queue_beat(OP_SAMPLE, 125000);
        queue_beat(OP_SAMPLE, 125001);
        queue_beat(OP_SAMPLE, INT_MAX_S);
        queue_beat(OP_SAMPLE, INT_MIN_S);
        queue_beat(OP_SAMPLE, -1);
        queue_beat(OP_SAMPLE, 131071);
        queue_beat(OP_SAMPLE, -131072);
        wait_drained();

        // Directed: empty range, zero min_valid with nothing valid, zero lookback.
        set_config(10, 5, 1, 0, 0);
        queue_beat(OP_CLEAR, -1);
        queue_beat(OP_SAMPLE, 7);
        queue_beat(OP_SAMPLE, 10);
        queue_beat(OP_SAMPLE, 5);
        queue_beat(OP_SAMPLE, 0);
        wait_drained();

        // Directed: full range, min_valid and lookback beyond the window depth.
        set_config(-131072, 131071, 1, 127, 127);
        queue_beat(OP_SAMPLE, 131071);
        queue_beat(OP_SAMPLE, -131072);
        queue_beat(OP_SAMPLE, 131072);
        queue_beat(OP_SAMPLE, -131073);
        queue_beat(OP_CLEAR, 0);
        queue_beat(OP_SAMPLE, -131073);
        wait_drained();

        // Random phases over several settings; the first one holds the receiver off.
        set_config(VALID_LOW_RST, VALID_HIGH_RST, AVG_ENABLE_RST, MIN_VALID_RST, LOOKBACK_RST);
        run_phase(0, 80, 2, 1'b1);

        set_config(-131072, 131071, 1, 1, 100);
        run_phase(1, 90, 3, 1'b0);

        set_config(-1000, 1000, 1, 0, 127);
        run_phase(2, 50, 3, 1'b0);

        // Every entry valid so that the full window count is reached.
        set_config(-131072, 131071, 1, 100, 0);
        run_phase(3, 100, 0, 1'b0);

        lo = $urandom_range(0, 262143) - 131072;
        hi = $urandom_range(0, 262143) - 131072;
        if (lo > hi && $urandom_range(0, 3) != 0) begin
            tmp = lo;
            lo  = hi;
            hi  = tmp;
        end
        set_config(lo, hi, $urandom_range(0, 1), $urandom_range(0, 127), $urandom_range(0, 127));
        run_phase(0, 70, 4, 1'b0);

        // Single-value range with averaging off.
        set_config(131071, 131071, 0, 10, 50);
        run_phase(1, 60, 3, 1'b0);

        lo = $urandom_range(0, 131071) - 131072;
        hi = $urandom_range(0, 131071);
        set_config(lo, hi, 1, 101, 101);
        run_phase(2, 85, 2, 1'b0);

        lo = $urandom_range(0, 100000) - 131072;
        hi = lo + $urandom_range(0, 20000);
        set_config(lo, hi, 1, $urandom_range(0, 60), $urandom_range(0, 100));
        run_phase(3, 75, 3, 1'b0);

        // Quiet period to catch any stray result beat.
        set_pacing(0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("validated_sample_window_stats regression: pass");
        end else begin
            $display("validated_sample_window_stats regression: fail");
        end
        $finish;
    end

endmodule
